### sv/aes_pkg.sv
// shared types, tables and byte-level functions of the aes-128 core
package aes_pkg;

   // request and response payloads
   typedef struct packed {
      logic        kind;
      logic [63:0] data_high;
      logic [63:0] data_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   // control of the shared round unit
   typedef struct packed {
      logic decrypt;
      logic first;
      logic last;
   } round_ctl_type;

   // register indexes
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;

   localparam int NumRounds = 10;

   typedef logic [7:0] sbox_table_type [256];
   typedef logic [7:0] rcon_table_type [NumRounds];

   localparam logic [7:0] REDUCE = 8'h1b;

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam rcon_table_type RCON = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // inverse table, built at elaboration from the forward one
   function automatic sbox_table_type build_inv_sbox();
      sbox_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[SBOX[i]] = i[7:0];
      end
      return t;
   endfunction

   localparam sbox_table_type INV_SBOX = build_inv_sbox();

   function automatic logic [7:0] get_byte(input logic [127:0] x, input int i);
      return x[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? REDUCE : 8'h00);
   endfunction

   // gf(2^8) multiply by a small constant
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p;
      logic [7:0] v;
      p = 8'h00;
      v = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) p = p ^ v;
         v = xtime(v);
      end
      return p;
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] x, input logic inv);
      logic [127:0] y;
      for (int i = 0; i < 16; i++) begin
         y[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(x, i)] : SBOX[get_byte(x, i)];
      end
      return y;
   endfunction

   // byte 4c+r holds row r, column c
   function automatic logic [127:0] shift_rows(input logic [127:0] x, input logic inv);
      logic [127:0] y;
      int src;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
            y[127 - 8 * (4 * c + r) -: 8] = get_byte(x, 4 * src + r);
         end
      end
      return y;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] x, input logic inv);
      logic [127:0] y;
      logic [3:0]   m [4];
      logic [7:0]   v;
      if (inv) m = '{4'd14, 4'd11, 4'd13, 4'd9};
      else     m = '{4'd2, 4'd3, 4'd1, 4'd1};
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) begin
               v = v ^ gmul(get_byte(x, 4 * c + k), m[(k - r + 4) & 3]);
            end
            y[127 - 8 * (4 * c + r) -: 8] = v;
         end
      end
      return y;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] n0, n1, n2, n3;
      t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      n0 = k[127:96] ^ t;
      n1 = k[95:64] ^ n0;
      n2 = k[63:32] ^ n1;
      n3 = k[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

### sv/aes128_block_cipher_core.sv
// aes-128 ecb encrypt/decrypt core with on-chip key expansion
//
//  channel  ports                                   handshake
//  request  start, busy, req_payload                accepted when start && !busy
//  response rsp_valid, rsp_payload                  one-cycle strobe, no backpressure
//  csr      csr_valid, csr_ready, csr_index, csr_data  write when valid && ready
//
// from acceptance to the response strobe a request makes one pass of
// the shared round unit for the key addition and one for each of ten rounds,
// plus the output register. the first request after reset or a key write first
// expands the key, one round key per cycle.
// reset is synchronous and clears the sequencer, the strobe and the key-valid flag.
// busy stays high from acceptance until the response strobe; the receiver cannot stall.
module aes128_block_cipher_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  aes_pkg::req_type req_payload,
   output logic             rsp_valid,
   output aes_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXPAND = 2'd1;
   localparam logic [1:0] ST_ROUND  = 2'd2;

   localparam logic [3:0] LAST_STEP = 4'(aes_pkg::NumRounds);

   logic [1:0]   fsm_ff, fsm_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         kind_ff, kind_in;
   logic         ready_ff, ready_in;
   logic         valid_ff, valid_in;
   logic [127:0] st_ff, st_in;
   logic [63:0]  key_hi_ff;
   logic [63:0]  key_lo_ff;
   logic [127:0] rk_ff [aes_pkg::NumRounds + 1];
   aes_pkg::rsp_type rsp_ff;

   logic         accept;
   logic [3:0]   rd_idx;
   logic [127:0] rk_rd;
   logic [127:0] rk_next;
   logic [127:0] round_out;
   aes_pkg::round_ctl_type ctl;

   assign accept    = start && !busy;
   assign busy      = (fsm_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff;
   assign rsp_payload = rsp_ff;

   // round key read select
   always_comb begin
      if (fsm_ff == ST_EXPAND) rd_idx = cnt_ff - 4'd1;
      else if (kind_ff)        rd_idx = LAST_STEP - cnt_ff;
      else                     rd_idx = cnt_ff;
   end
   assign rk_rd   = rk_ff[rd_idx];
   assign rk_next = aes_pkg::next_key(rk_rd, aes_pkg::RCON[rd_idx]);

   assign ctl.decrypt = kind_ff;
   assign ctl.first   = (cnt_ff == 4'd0);
   assign ctl.last    = (cnt_ff == LAST_STEP);

   aes_round u_round (
      .ctl       (ctl),
      .state     (st_ff),
      .round_key (rk_rd),
      .result    (round_out)
   );

   // sequencer
   always_comb begin
      fsm_in   = fsm_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      ready_in = ready_ff;
      valid_in = 1'b0;
      st_in    = st_ff;
      unique case (fsm_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_payload.kind;
               st_in   = {req_payload.data_high, req_payload.data_low};
               if (ready_ff) begin
                  fsm_in = ST_ROUND;
                  cnt_in = 4'd0;
               end else begin
                  fsm_in = ST_EXPAND;
                  cnt_in = 4'd1;
               end
            end
         end
         ST_EXPAND: begin
            if (cnt_ff == LAST_STEP) begin
               fsm_in   = ST_ROUND;
               cnt_in   = 4'd0;
               ready_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_ROUND: begin
            st_in = round_out;
            if (cnt_ff == LAST_STEP) begin
               fsm_in   = ST_IDLE;
               valid_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase
      // key write invalidates the expanded keys
      if (csr_valid && (csr_index == aes_pkg::CSR_KEY_HIGH ||
                        csr_index == aes_pkg::CSR_KEY_LOW)) begin
         ready_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff   <= ST_IDLE;
         cnt_ff   <= 4'd0;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
         kind_ff  <= 1'b0;
      end else begin
         fsm_ff   <= fsm_in;
         cnt_ff   <= cnt_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
         kind_ff  <= kind_in;
      end
   end

   // data path and key registers
   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (fsm_ff == ST_ROUND && cnt_ff == LAST_STEP) begin
         rsp_ff <= round_out;
      end
      if (fsm_ff == ST_IDLE && accept && !ready_ff) begin
         rk_ff[0] <= {key_hi_ff, key_lo_ff};
      end
      if (fsm_ff == ST_EXPAND) begin
         rk_ff[cnt_ff] <= rk_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= 64'd0;
         key_lo_ff <= 64'd0;
      end else if (csr_valid) begin
         if (csr_index == aes_pkg::CSR_KEY_HIGH) key_hi_ff <= csr_data;
         if (csr_index == aes_pkg::CSR_KEY_LOW)  key_lo_ff <= csr_data;
      end
   end

endmodule

### sv/aes_round.sv
// shared round unit: one encrypt or decrypt round, or the initial key addition
module aes_round (
   input  aes_pkg::round_ctl_type ctl,
   input  logic [127:0]           state,
   input  logic [127:0]           round_key,
   output logic [127:0]           result
);

   logic [127:0] enc_sr;
   logic [127:0] enc_mx;
   logic [127:0] dec_ak;
   logic [127:0] dec_mx;

   // forward round: sub, shift, mix (not in last), add key
   assign enc_sr = aes_pkg::shift_rows(aes_pkg::sub_bytes(state, 1'b0), 1'b0);
   assign enc_mx = ctl.last ? enc_sr : aes_pkg::mix_columns(enc_sr, 1'b0);

   // inverse round: shift, sub, add key, mix (not in last)
   assign dec_ak = aes_pkg::sub_bytes(aes_pkg::shift_rows(state, 1'b1), 1'b1) ^ round_key;
   assign dec_mx = ctl.last ? dec_ak : aes_pkg::mix_columns(dec_ak, 1'b1);

   always_comb begin
      if (ctl.first)        result = state ^ round_key;
      else if (ctl.decrypt) result = dec_mx;
      else                  result = enc_mx ^ round_key;
   end

endmodule

### sv/aes_checker.sv
// port-level checks of the aes-128 core and their bind
module aes_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // busy drops right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   // an accepted request makes the core busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but core not busy");

   // a response only ends a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response without a request in flight");

   // response strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

bind aes128_block_cipher_core aes_checker u_aes_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

### tb/aes128_block_cipher_core_tb.sv
// self-checking testbench for the aes-128 ecb encrypt/decrypt core
`timescale 1ns / 100ps

module aes128_block_cipher_core_tb;

   localparam int  CycleLimit   = 400000;
   localparam int  RandomBlocks = 800;
   localparam int  DrainCycles  = 30;
   // index past the end of the register list, writes are dropped
   localparam logic [1:0] CSR_NONE_A = 2'd2;
   localparam logic [1:0] CSR_NONE_B = 2'd3;
   localparam logic KIND_ENC = 1'b0;
   localparam logic KIND_DEC = 1'b1;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   aes_pkg::req_type req_payload;
   logic             rsp_valid;
   aes_pkg::rsp_type rsp_payload;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [63:0]      csr_data;

   aes128_block_cipher_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // predictor state
   logic [63:0]      key_hi_shadow;
   logic [63:0]      key_lo_shadow;
   logic             schedule_valid;
   logic [127:0]     round_keys [11];
   logic [7:0]       inv_sub [256];
   aes_pkg::rsp_type pending_blocks [$];
   int               error_count;
   int               cycle_count;
   bit               gaps_enabled;

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ a;
         a = gf_double(a);
      end
      return acc;
   endfunction

   // eleven round keys from the current key registers
   function automatic void build_schedule();
      logic [31:0] w [44];
      logic [31:0] t;
      w[0] = key_hi_shadow[63:32];
      w[1] = key_hi_shadow[31:0];
      w[2] = key_lo_shadow[63:32];
      w[3] = key_lo_shadow[31:0];
      for (int i = 4; i < 44; i++) begin
         t = w[i - 1];
         if ((i % 4) == 0)
            t = {aes_pkg::SBOX[t[23:16]] ^ aes_pkg::RCON[i / 4 - 1],
                 aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]],
                 aes_pkg::SBOX[t[31:24]]};
         w[i] = w[i - 4] ^ t;
      end
      for (int k = 0; k < 11; k++)
         round_keys[k] = {w[4 * k], w[4 * k + 1], w[4 * k + 2], w[4 * k + 3]};
      schedule_valid = 1'b1;
   endfunction

   // full block transform, byte 4c+r is row r of column c
   function automatic logic [127:0] aes_transform(input logic dec, input logic [127:0] blk);
      logic [7:0]   st [16];
      logic [7:0]   tmp [16];
      logic [7:0]   mat [4];
      logic [7:0]   v;
      logic [127:0] res;
      int           src;
      int           rk;
      if (!schedule_valid) build_schedule();
      if (dec) mat = '{8'd14, 8'd11, 8'd13, 8'd9};
      else     mat = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int i = 0; i < 16; i++) st[i] = blk[127 - 8 * i -: 8];
      for (int i = 0; i < 16; i++) st[i] ^= round_keys[dec ? 10 : 0][127 - 8 * i -: 8];
      for (int step = 1; step <= 10; step++) begin
         rk = dec ? 10 - step : step;
         // sub bytes and shift rows commute
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
               src = dec ? ((c - r + 4) & 3) : ((c + r) & 3);
               tmp[4 * c + r] = dec ? inv_sub[st[4 * src + r]]
                                    : aes_pkg::SBOX[st[4 * src + r]];
            end
         st = tmp;
         if (dec)
            for (int i = 0; i < 16; i++) st[i] ^= round_keys[rk][127 - 8 * i -: 8];
         if (step < 10) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  v = 8'h00;
                  for (int k = 0; k < 4; k++)
                     v ^= gf_mult(mat[(k - r + 4) & 3], st[4 * c + k]);
                  tmp[4 * c + r] = v;
               end
            st = tmp;
         end
         if (!dec)
            for (int i = 0; i < 16; i++) st[i] ^= round_keys[rk][127 - 8 * i -: 8];
      end
      for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
      return res;
   endfunction

   // random idle cycle of the sender
   function automatic bit idle_now();
      return gaps_enabled && ($urandom_range(99) < 9);
   endfunction

   // issue one request and queue its predicted response
   task automatic send_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo,
                             input bit has_ref, input logic [127:0] ref_blk);
      aes_pkg::rsp_type exp_rsp;
      bit               drive;
      req_payload <= '{kind: kind, data_high: hi, data_low: lo};
      do begin
         drive = !idle_now();
         start <= drive;
         @(posedge clock);
      end while (!drive || busy);
      exp_rsp = aes_transform(kind, {hi, lo});
      if (has_ref && exp_rsp.result_high != ref_blk[127:64]) begin
         $error("predictor result_high: expected %h actual %h", ref_blk[127:64],
                exp_rsp.result_high);
         error_count++;
      end
      if (has_ref && exp_rsp.result_low != ref_blk[63:0]) begin
         $error("predictor result_low: expected %h actual %h", ref_blk[63:0],
                exp_rsp.result_low);
         error_count++;
      end
      pending_blocks.push_back(exp_rsp);
   endtask

   // stop requesting and wait for every response
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_blocks.size() != 0 || busy);
   endtask

   // register writes while the core is idle
   task automatic write_regs(input logic [1:0] idx [$], input logic [63:0] val [$]);
      for (int i = 0; i < idx.size(); i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         if (idx[i] == aes_pkg::CSR_KEY_HIGH) begin
            key_hi_shadow  = val[i];
            schedule_valid = 1'b0;
         end else if (idx[i] == aes_pkg::CSR_KEY_LOW) begin
            key_lo_shadow  = val[i];
            schedule_valid = 1'b0;
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
      drain();
      write_regs('{aes_pkg::CSR_KEY_HIGH, aes_pkg::CSR_KEY_LOW}, '{hi, lo});
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      aes_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_blocks.size() == 0) begin
            $error("unexpected response: result_high %h result_low %h",
                   rsp_payload.result_high, rsp_payload.result_low);
            error_count++;
         end else begin
            exp_rsp = pending_blocks.pop_front();
            if (rsp_payload.result_high !== exp_rsp.result_high) begin
               $error("result_high: expected %h actual %h", exp_rsp.result_high,
                      rsp_payload.result_high);
               error_count++;
            end
            if (rsp_payload.result_low !== exp_rsp.result_low) begin
               $error("result_low: expected %h actual %h", exp_rsp.result_low,
                      rsp_payload.result_low);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // directed requests, known answers where has_ref is set
   typedef struct {
      logic         kind;
      logic [63:0]  hi;
      logic [63:0]  lo;
      bit           has_ref;
      logic [127:0] ref_blk;
   } vector_row_type;

   localparam logic [127:0] FIPS_PT = 128'h00112233445566778899aabbccddeeff;
   localparam logic [127:0] FIPS_CT = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;

   vector_row_type zero_key_rows [] = '{
      '{KIND_ENC, 64'h0, 64'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{KIND_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 128'h0},
      '{KIND_ENC, '1, '1, 1'b0, '0},
      '{KIND_DEC, '1, '1, 1'b0, '0}
   };

   vector_row_type fips_rows [] = '{
      '{KIND_ENC, FIPS_PT[127:64], FIPS_PT[63:0], 1'b1, FIPS_CT},
      '{KIND_DEC, FIPS_CT[127:64], FIPS_CT[63:0], 1'b1, FIPS_PT},
      '{KIND_ENC, 64'h0, 64'h0, 1'b0, '0},
      '{KIND_DEC, 64'h0, 64'h0, 1'b0, '0},
      '{KIND_ENC, '1, '1, 1'b0, '0},
      '{KIND_DEC, '1, '1, 1'b0, '0},
      '{KIND_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, '0},
      '{KIND_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0},
      '{KIND_ENC, 64'h8000000000000000, 64'h0000000000000001, 1'b0, '0},
      '{KIND_DEC, 64'h0000000000000001, 64'h8000000000000000, 1'b0, '0}
   };

   initial begin
      logic [63:0] hi;
      logic [63:0] lo;
      error_count    = 0;
      cycle_count    = 0;
      gaps_enabled   = 1'b1;
      key_hi_shadow  = '0;
      key_lo_shadow  = '0;
      schedule_valid = 1'b0;
      for (int i = 0; i < 256; i++) inv_sub[aes_pkg::SBOX[i]] = i[7:0];
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= aes_pkg::CSR_KEY_HIGH;
      csr_data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset key of all zeros, no write yet
      foreach (zero_key_rows[i])
         send_block(zero_key_rows[i].kind, zero_key_rows[i].hi, zero_key_rows[i].lo,
                    zero_key_rows[i].has_ref, zero_key_rows[i].ref_blk);
      set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      foreach (fips_rows[i])
         send_block(fips_rows[i].kind, fips_rows[i].hi, fips_rows[i].lo,
                    fips_rows[i].has_ref, fips_rows[i].ref_blk);
      // writes past the register list leave the key alone
      drain();
      write_regs('{CSR_NONE_A, CSR_NONE_B}, '{'1, '1});
      send_block(KIND_ENC, FIPS_PT[127:64], FIPS_PT[63:0], 1'b1, FIPS_CT);
      // all-ones key, then the low key word changed between two pairs of items
      set_key('1, '1);
      send_block(KIND_ENC, '1, '1, 1'b0, '0);
      send_block(KIND_DEC, '0, '0, 1'b0, '0);
      drain();
      write_regs('{aes_pkg::CSR_KEY_LOW}, '{64'h0123456789abcdef});
      send_block(KIND_ENC, 64'hfedcba9876543210, '0, 1'b0, '0);
      send_block(KIND_DEC, '0, 64'hfedcba9876543210, 1'b0, '0);

      // random blocks, new key every so often
      for (int n = 0; n < RandomBlocks; n++) begin
         gaps_enabled = !(n >= 300 && n < 450);
         if (n % 80 == 0) begin
            drain();
            case ($urandom_range(3))
               0: write_regs('{aes_pkg::CSR_KEY_HIGH}, '{rand_word()});
               1: write_regs('{aes_pkg::CSR_KEY_LOW,
                               $urandom_range(1) ? CSR_NONE_A : CSR_NONE_B},
                             '{rand_word(), rand_word()});
               default: write_regs('{aes_pkg::CSR_KEY_HIGH, aes_pkg::CSR_KEY_LOW},
                                   '{rand_word(), rand_word()});
            endcase
         end
         hi = rand_word();
         lo = rand_word();
         send_block($urandom_range(1), hi, lo, 1'b0, '0);
      end

      drain();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
